// File: design/pvd_pkg.sv
// Package with constants, types and helper functions for the prefix varint decoder.
package pvd_pkg;

  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CountWidth = 3;
  localparam int unsigned ShiftWidth = 5;

  localparam logic [ByteWidth-1:0] PrefixTwo   = 8'h80;
  localparam logic [ByteWidth-1:0] PrefixThree = 8'hA0;
  localparam logic [ByteWidth-1:0] PrefixFour  = 8'hC0;
  localparam logic [ByteWidth-1:0] PrefixRaw   = 8'hE0;
  localparam logic [ByteWidth-1:0] LowMask     = 8'h1F;

  localparam logic [ValueWidth-1:0] OffsetTwo   = 32'h0000_0080;
  localparam logic [ValueWidth-1:0] OffsetThree = 32'h0000_1F80;
  localparam logic [ValueWidth-1:0] OffsetFour  = 32'h001F_1F80;

  localparam logic [CountWidth-1:0] LenIdle  = 3'd0;
  localparam logic [CountWidth-1:0] LenOne   = 3'd1;
  localparam logic [CountWidth-1:0] LenTwo   = 3'd2;
  localparam logic [CountWidth-1:0] LenThree = 3'd3;
  localparam logic [CountWidth-1:0] LenFour  = 3'd4;
  localparam logic [CountWidth-1:0] LenRaw   = 3'd5;

  typedef struct packed {
    logic                  valid;
    logic [ValueWidth-1:0] value;
    logic [CountWidth-1:0] byte_count;
  } result_t;

  function automatic logic [ValueWidth-1:0] form_offset(input logic [CountWidth-1:0] len);
    logic [ValueWidth-1:0] off;
    case (len)
      LenTwo:   off = OffsetTwo;
      LenThree: off = OffsetThree;
      LenFour:  off = OffsetFour;
      default:  off = '0;
    endcase
    return off;
  endfunction

  // Bit position of a continuation byte within the value.
  function automatic logic [ShiftWidth-1:0] byte_shift(input logic [CountWidth-1:0] len,
                                                       input logic [CountWidth-1:0] seen);
    logic [1:0]            slot;
    logic [ShiftWidth-1:0] base;
    slot = 2'(seen - LenOne);
    base = {slot, 3'b000};
    if (len == LenRaw) begin
      return base;
    end
    return ShiftWidth'(base + ShiftWidth'(5));
  endfunction

endpackage

// File: design/pvd_if.sv
// Handshake interfaces for the byte input channel and the result output channel.
interface pvd_byte_if;
  logic                           valid;
  logic                           ready;
  logic [pvd_pkg::ByteWidth-1:0]  in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface pvd_result_if;
  logic                            valid;
  logic                            ready;
  logic [pvd_pkg::ValueWidth-1:0]  value;
  logic [pvd_pkg::CountWidth-1:0]  byte_count;

  modport source (output valid, output value, output byte_count, input ready);
  modport sink   (input valid, input value, input byte_count, output ready);
endinterface

// File: design/prefix_varint_decoder.sv
// Top level of the prefix-length varint decoder for unsigned 32-bit values.
//
// The bytes channel takes one byte of the encoded stream per beat. The results
// channel gives one beat per decoded value, carrying the value and the number
// of bytes it occupied, in stream order. Bytes that do not finish a value give
// no result beat.
// A byte accepted on the bytes channel is captured in the input register and
// decoded from there into the result register once that register is free.
// The block takes one byte every cycle while the result register is free; the
// decode state update is a single shift, merge and add between the input
// register and the result register. When the receiver stalls, the result
// register holds its beat, the input register fills, and the bytes channel
// drops ready until the result leaves. Reset is synchronous: it empties both
// registers and returns the decoder to the start of a value, so the next byte
// is read as a prefix.
module prefix_varint_decoder (
  input logic         clk,
  input logic         rst,
  pvd_byte_if.sink    bytes,
  pvd_result_if.source results
);

  logic                          held_valid;
  logic [pvd_pkg::ByteWidth-1:0] held_byte;
  logic                          out_free;
  logic                          advance;
  pvd_pkg::result_t              result;

  assign advance = held_valid && out_free;

  pvd_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (bytes.valid),
    .in_byte    (bytes.in_byte),
    .in_ready   (bytes.ready),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  pvd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .held_byte (held_byte),
    .result    (result)
  );

  pvd_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .result    (result),
    .free      (out_free),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_value (results.value),
    .out_count (results.byte_count)
  );

endmodule

// File: design/pvd_in_stage.sv
// Input register that captures one byte beat per cycle while it is empty or its byte moves on to the decoder.
module pvd_in_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [pvd_pkg::ByteWidth-1:0] in_byte,
  output logic                          in_ready,
  input  logic                          advance,
  output logic                          held_valid,
  output logic [pvd_pkg::ByteWidth-1:0] held_byte
);

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= in_byte;
    end
  end

endmodule

// File: design/pvd_core.sv
// Decode state and per-byte merge logic of the prefix varint decoder.
module pvd_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic [pvd_pkg::ByteWidth-1:0] held_byte,
  output pvd_pkg::result_t              result
);

  logic [pvd_pkg::CountWidth-1:0] form_length, form_length_next;
  logic [pvd_pkg::CountWidth-1:0] bytes_seen, bytes_seen_next;
  logic [pvd_pkg::ValueWidth-1:0] partial_value, partial_value_next;
  logic [pvd_pkg::ValueWidth-1:0] merged;
  logic [pvd_pkg::CountWidth-1:0] seen_inc;

  always_comb begin
    merged   = partial_value |
               (pvd_pkg::ValueWidth'(held_byte) << pvd_pkg::byte_shift(form_length, bytes_seen));
    seen_inc = pvd_pkg::CountWidth'(bytes_seen + pvd_pkg::LenOne);

    form_length_next   = form_length;
    bytes_seen_next    = bytes_seen;
    partial_value_next = partial_value;
    result.valid       = 1'b0;
    result.value       = merged + pvd_pkg::form_offset(form_length);
    result.byte_count  = form_length;

    if (form_length == pvd_pkg::LenIdle) begin
      if (held_byte < pvd_pkg::PrefixTwo) begin
        result.valid      = 1'b1;
        result.value      = pvd_pkg::ValueWidth'(held_byte);
        result.byte_count = pvd_pkg::LenOne;
      end else begin
        if (held_byte < pvd_pkg::PrefixThree) begin
          form_length_next = pvd_pkg::LenTwo;
        end else if (held_byte < pvd_pkg::PrefixFour) begin
          form_length_next = pvd_pkg::LenThree;
        end else if (held_byte < pvd_pkg::PrefixRaw) begin
          form_length_next = pvd_pkg::LenFour;
        end else begin
          form_length_next = pvd_pkg::LenRaw;
        end
        partial_value_next = (held_byte >= pvd_pkg::PrefixRaw) ? '0 :
                             pvd_pkg::ValueWidth'(held_byte & pvd_pkg::LowMask);
        bytes_seen_next    = pvd_pkg::LenOne;
      end
    end else if (seen_inc >= form_length) begin
      result.valid       = 1'b1;
      form_length_next   = pvd_pkg::LenIdle;
      bytes_seen_next    = pvd_pkg::LenIdle;
      partial_value_next = '0;
    end else begin
      partial_value_next = merged;
      bytes_seen_next    = seen_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      form_length   <= pvd_pkg::LenIdle;
      bytes_seen    <= pvd_pkg::LenIdle;
      partial_value <= '0;
    end else if (advance) begin
      form_length   <= form_length_next;
      bytes_seen    <= bytes_seen_next;
      partial_value <= partial_value_next;
    end
  end

endmodule

// File: design/pvd_out_stage.sv
// Result register that holds a decoded value until the receiver takes it.
module pvd_out_stage (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  pvd_pkg::result_t               result,
  output logic                           free,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pvd_pkg::ValueWidth-1:0] out_value,
  output logic [pvd_pkg::CountWidth-1:0] out_count
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load && result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load && result.valid) begin
      out_value <= result.value;
      out_count <= result.byte_count;
    end
  end

endmodule

// File: design/pvd_checker.sv
// Port-level checker for the prefix varint decoder, bound to the top level.
module pvd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [pvd_pkg::ValueWidth-1:0] out_value,
  input logic [pvd_pkg::CountWidth-1:0] out_count
);

  // A result beat always reports a length between one and five bytes.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_count == pvd_pkg::LenOne || out_count == pvd_pkg::LenTwo ||
                   out_count == pvd_pkg::LenThree || out_count == pvd_pkg::LenFour ||
                   out_count == pvd_pkg::LenRaw))
    else $error("result beat with impossible byte count");

  // Single-byte values are below the two-byte prefix, two-byte values lie in their window.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_count == pvd_pkg::LenOne) |-> (out_value < 32'h80))
    else $error("single-byte result out of range");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_count == pvd_pkg::LenTwo) |->
      (out_value >= 32'h80 && out_value <= 32'h207F))
    else $error("two-byte result out of range");

  // A stalled result beat holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_value) && $stable(out_count)))
    else $error("stalled result beat changed");

  // Reset leaves no result beat pending.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat present after reset");

endmodule

bind prefix_varint_decoder pvd_checker u_pvd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_value (results.value),
  .out_count (results.byte_count)
);

// File: bench/prefix_varint_decoder_tb.sv
// Testbench for the prefix varint decoder: random bursts of encoded bytes checked against a predictor.
module prefix_varint_decoder_tb;
  import pvd_pkg::*;

  typedef struct {
    logic [ValueWidth-1:0] value;
    logic [CountWidth-1:0] byte_count;
  } decoded_t;

  typedef enum int {RxOpen, RxCoin, RxSparse, RxBlocked} rx_mode_e;

  localparam int unsigned RandomBytes = 450;
  localparam int unsigned IdleLimit   = 2000;

  logic clk;
  logic rst;

  pvd_byte_if   byte_ch ();
  pvd_result_if res_ch ();

  prefix_varint_decoder dut (
    .clk     (clk),
    .rst     (rst),
    .bytes   (byte_ch),
    .results (res_ch)
  );

  logic [ByteWidth-1:0] pending_bytes [$];
  decoded_t             expected_values [$];

  logic [CountWidth-1:0] dec_len;
  logic [CountWidth-1:0] dec_seen;
  logic [ValueWidth-1:0] dec_acc;

  int unsigned fail_count;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned rx_cycle;
  int unsigned idle_cycles;
  rx_mode_e    rx_mode;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicts the decoder's response to one accepted byte.
  task automatic decode_byte(input logic [ByteWidth-1:0] b);
    decoded_t              r;
    int unsigned           sh;
    logic [ValueWidth-1:0] off;
    if (dec_len == LenIdle) begin
      if (b < PrefixTwo) begin
        r.value      = ValueWidth'(b);
        r.byte_count = LenOne;
        expected_values.push_back(r);
      end else begin
        if (b < PrefixThree) begin
          dec_len = LenTwo;
        end else if (b < PrefixFour) begin
          dec_len = LenThree;
        end else if (b < PrefixRaw) begin
          dec_len = LenFour;
        end else begin
          dec_len = LenRaw;
        end
        dec_acc  = (dec_len == LenRaw) ? '0 : ValueWidth'(b & LowMask);
        dec_seen = LenOne;
      end
    end else begin
      sh = 8 * (int'(dec_seen) - 1);
      if (dec_len != LenRaw) begin
        sh = sh + 5;
      end
      dec_acc  = dec_acc | (ValueWidth'(b) << sh);
      dec_seen = dec_seen + 1'b1;
      if (dec_seen == dec_len) begin
        case (dec_len)
          LenTwo:   off = OffsetTwo;
          LenThree: off = OffsetThree;
          LenFour:  off = OffsetFour;
          default:  off = '0;
        endcase
        r.value      = dec_acc + off;
        r.byte_count = dec_len;
        expected_values.push_back(r);
        dec_len  = LenIdle;
        dec_seen = '0;
        dec_acc  = '0;
      end
    end
  endtask

  // Appends one encoded value, or occasionally a stray byte, to the stimulus.
  task automatic queue_random_value(output int unsigned added);
    int unsigned          form;
    int unsigned          extra;
    logic [ByteWidth-1:0] b;
    form = $urandom_range(0, 9);
    case (form)
      0, 1: begin
        b = ByteWidth'($urandom_range(0, 127));
        extra = 0;
      end
      2, 3: begin
        b = PrefixTwo | ByteWidth'($urandom_range(0, 31));
        extra = 1;
      end
      4, 5: begin
        b = PrefixThree | ByteWidth'($urandom_range(0, 31));
        extra = 2;
      end
      6, 7: begin
        b = PrefixFour | ByteWidth'($urandom_range(0, 31));
        extra = 3;
      end
      8: begin
        b = PrefixRaw | ByteWidth'($urandom_range(0, 31));
        extra = 4;
      end
      default: begin
        b = ByteWidth'($urandom_range(0, 255));
        extra = 0;
      end
    endcase
    pending_bytes.push_back(b);
    for (int i = 0; i < extra; i++) begin
      case ($urandom_range(0, 7))
        0:       b = 8'hFF;
        1:       b = 8'h00;
        default: b = ByteWidth'($urandom_range(0, 255));
      endcase
      pending_bytes.push_back(b);
    end
    added = extra + 1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      byte_ch.valid   <= 1'b0;
      byte_ch.in_byte <= '0;
      burst_left = $urandom_range(1, 40);
      gap_left   = 0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        decode_byte(byte_ch.in_byte);
        void'(pending_bytes.pop_front());
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          if ($urandom_range(0, 3) == 0) begin
            gap_left = 0;
          end else if ($urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(8, 25);
          end else begin
            gap_left = $urandom_range(1, 4);
          end
        end else begin
          burst_left = burst_left - 1;
        end
      end
      if (!(byte_ch.valid && !byte_ch.ready)) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          byte_ch.valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          byte_ch.valid   <= 1'b1;
          byte_ch.in_byte <= pending_bytes[0];
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      rx_cycle = 0;
      rx_mode  = RxOpen;
    end else begin
      if (rx_cycle % 50 == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
      end
      case (rx_mode)
        RxOpen:    res_ch.ready <= 1'b1;
        RxCoin:    res_ch.ready <= 1'($urandom_range(0, 1));
        RxSparse:  res_ch.ready <= ($urandom_range(0, 3) == 0);
        default:   res_ch.ready <= ((rx_cycle % 16) >= 12);
      endcase
      rx_cycle = rx_cycle + 1;
    end
  end

  always @(posedge clk) begin
    decoded_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_values.size() == 0) begin
        $error("unexpected result beat: value %h, byte_count %0d",
               res_ch.value, res_ch.byte_count);
        fail_count = fail_count + 1;
      end else begin
        want = expected_values.pop_front();
        if (res_ch.value !== want.value) begin
          $error("value: expected %h, got %h", want.value, res_ch.value);
          fail_count = fail_count + 1;
        end
        if (res_ch.byte_count !== want.byte_count) begin
          $error("byte_count: expected %0d, got %0d", want.byte_count, res_ch.byte_count);
          fail_count = fail_count + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [ByteWidth-1:0] directed_bytes [$];
    int unsigned          total;
    int unsigned          added;
    fail_count      = 0;
    idle_cycles     = 0;
    dec_len         = LenIdle;
    dec_seen        = '0;
    dec_acc         = '0;
    byte_ch.valid   = 1'b0;
    byte_ch.in_byte = '0;
    res_ch.ready    = 1'b0;
    rst             = 1'b1;

    // One- and two-byte extremes, four-byte and raw maxima; continuation bytes that look like prefixes.
    directed_bytes = '{8'h00, 8'h7F,
                       8'h80, 8'h00,
                       8'h9F, 8'hFF,
                       8'hA5, 8'h80, 8'hC3,
                       8'hDF, 8'hFF, 8'hFF, 8'hFF,
                       8'hE0, 8'h78, 8'h56, 8'h34, 8'h12,
                       8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    foreach (directed_bytes[i]) begin
      pending_bytes.push_back(directed_bytes[i]);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || expected_values.size() != 0) begin
      @(posedge clk);
    end

    total = 0;
    while (total < RandomBytes) begin
      queue_random_value(added);
      total = total + added;
    end

    while (pending_bytes.size() != 0 || expected_values.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
design/pvd_pkg.sv
design/pvd_if.sv
design/pvd_in_stage.sv
design/pvd_core.sv
design/pvd_out_stage.sv
design/prefix_varint_decoder.sv
design/pvd_checker.sv
bench/prefix_varint_decoder_tb.sv
